@@ rtl/sba_pkg.sv @@
// package for the stochastic bitstream adder
// holds field widths, lane size, register indexes and the mode struct
// no dependencies
package sba_pkg;

  localparam int InBitsW        = 16;
  localparam int LaneW          = 4;
  localparam int InputCountDef  = 16;
  localparam int DiffWidthDef   = 16;
  localparam int StepTwo        = 2;

  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 1;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SCALED   = 1'b0,
    REG_UNIPOLAR = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic scaled;
    logic unipolar;
  } mode_t;

endpackage

@@ rtl/sba_lane.sv @@
// one counting lane: registered count of ones over a slice of the input bits
// depends on sba_pkg
module sba_lane #(
  parameter int LCntW = $clog2(sba_pkg::LaneW + 1)
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [sba_pkg::LaneW-1:0] bits_i,
  output logic [LCntW-1:0]         cnt_o
);

  logic [LCntW-1:0] cnt_d;
  logic [LCntW-1:0] cnt_q;

  always_comb begin
    cnt_d = '0;
    for (int b = 0; b < sba_pkg::LaneW; b++) begin
      cnt_d = cnt_d + LCntW'(bits_i[b]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cnt_q <= cnt_d;
    end
  end

  assign cnt_o = cnt_q;

endmodule

@@ rtl/sba_merge.sv @@
// merging stage: sums the lane counts and updates the scaled accumulator
// or the saturating difference register, producing the output bit
// depends on sba_pkg
module sba_merge #(
  parameter int InputCount = sba_pkg::InputCountDef,
  parameter int DiffWidth  = sba_pkg::DiffWidthDef,
  parameter int Lanes      = 4,
  parameter int LCntW      = $clog2(sba_pkg::LaneW + 1),
  parameter int ActN       = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        upd_i,
  input  sba_pkg::mode_t              mode_i,
  input  logic [Lanes-1:0][LCntW-1:0] lane_cnt_i,
  output logic                        bit_o
);

  localparam int  CntW       = $clog2(ActN + 1);
  localparam int  AccW       = $clog2(InputCount);
  localparam int  SumW       = AccW + 1;
  localparam int  ExtW       = DiffWidth + 2;
  localparam bit  FullCanSet = (InputCount <= sba_pkg::InBitsW);

  logic [CntW-1:0]                cnt;
  logic                           cnt_full;
  logic [CntW-1:0]                cnt_mod;
  logic [SumW-1:0]                acc_sum;
  logic [AccW-1:0]                acc_d, acc_q;
  logic                           bit_scaled;

  logic signed [DiffWidth-1:0]    diff_d, diff_q;
  logic signed [ExtW-1:0]         diff_ext, cnt2, offset, dsum, dclamp, dmax, dmin;
  logic                           bit_unscaled;

  always_comb begin
    cnt = '0;
    for (int l = 0; l < Lanes; l++) begin
      cnt = cnt + CntW'(lane_cnt_i[l]);
    end
  end

  // scaled path
  assign cnt_full = FullCanSet && (cnt == CntW'(ActN));
  assign cnt_mod  = cnt_full ? '0 : cnt;
  assign acc_sum  = {1'b0, acc_q} + SumW'(cnt_mod);

  always_comb begin
    acc_d      = acc_sum[AccW-1:0];
    bit_scaled = 1'b0;
    if (cnt_full) begin
      bit_scaled = 1'b1;
      acc_d      = acc_q;
    end else if (acc_sum >= SumW'(InputCount)) begin
      bit_scaled = 1'b1;
      acc_d      = AccW'(acc_sum - SumW'(InputCount));
    end
  end

  // unscaled path
  assign diff_ext = {{2{diff_q[DiffWidth-1]}}, diff_q};
  assign cnt2     = ExtW'({cnt, 1'b0});
  assign offset   = mode_i.unipolar ? '0 : ExtW'(InputCount - 1);
  assign dsum     = diff_ext + cnt2 - offset;
  assign dmax     = {3'b000, {(DiffWidth-1){1'b1}}};
  assign dmin     = {3'b111, {(DiffWidth-1){1'b0}}};

  always_comb begin
    if (dsum > dmax) begin
      dclamp = dmax;
    end else if (dsum < dmin) begin
      dclamp = dmin;
    end else begin
      dclamp = dsum;
    end
    bit_unscaled = (dclamp > 0);
    if (bit_unscaled) begin
      diff_d = DiffWidth'(dclamp - ExtW'(sba_pkg::StepTwo));
    end else begin
      diff_d = DiffWidth'(dclamp);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      diff_q <= '0;
    end else if (upd_i) begin
      if (mode_i.scaled) begin
        acc_q <= acc_d;
      end else begin
        diff_q <= diff_d;
      end
    end
  end

  assign bit_o = mode_i.scaled ? bit_scaled : bit_unscaled;

  a_acc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, acc_q} < SumW'(InputCount))
    else $error("scaled accumulator out of range");

  a_diff_after_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_i && !mode_i.scaled && bit_unscaled |=>
      (diff_q[DiffWidth-1] == 1'b0) || (diff_q == '1))
    else $error("difference register below -1 after a one");

  a_diff_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_i && mode_i.scaled |=> diff_q == $past(diff_q))
    else $error("difference register changed in scaled mode");

endmodule

@@ rtl/stochastic_bitstream_adder_top.sv @@
// stochastic bitstream adder, top level
// uses sba_pkg, sba_lane and sba_merge
//
// Usage:
//   input channel: in_valid_i / in_stall_o with in_bits_i, one bit from each
//   stream; bit i is stream i, bits at or above INPUT_COUNT are ignored.
//   output channel: out_valid_o / out_stall_i with out_bit_o, one output
//   bit for every input transfer, in order.
//   configuration: cfg_we_i writes cfg_wdata_i to register cfg_idx_i
//   (0 scaled_mode, 1 unipolar_mode); write only while the block is idle.
//   Path: an accepted bit is counted into the lane count register, then
//   merged into the output register that drives out_bit_o; a stall can hold it.
//   Throughput: one item per cycle unless the receiver stalls; the lane count
//   register feeds the combinational merge, state update and output register.
//   Reset: both modes come up as 1, accumulator and difference register
//   clear to zero, no result is pending.
//   Receiver stall: the output register holds its bit; if the lane stage is
//   empty, one more item is still taken into it, then in_stall_o rises.
module stochastic_bitstream_adder_top #(
  parameter int INPUT_COUNT = sba_pkg::InputCountDef,
  parameter int DIFF_WIDTH  = sba_pkg::DiffWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sba_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [sba_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [sba_pkg::InBitsW-1:0]   in_bits_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          out_bit_o
);

  localparam int ActN  = (INPUT_COUNT < sba_pkg::InBitsW) ? INPUT_COUNT : sba_pkg::InBitsW;
  localparam int Lanes = (ActN + sba_pkg::LaneW - 1) / sba_pkg::LaneW;
  localparam int PadW  = Lanes * sba_pkg::LaneW;
  localparam int LCntW = $clog2(sba_pkg::LaneW + 1);

  sba_pkg::mode_t              mode_q;
  logic                        lane_valid_q;
  logic                        out_valid_q;
  logic                        out_bit_q;
  logic                        out_adv, lane_adv, in_xfer, upd;
  logic                        merge_bit;
  logic [PadW-1:0]             in_pad;
  logic [Lanes-1:0][LCntW-1:0] lane_cnt;

  assign out_adv  = !out_valid_q || !out_stall_i;
  assign lane_adv = !lane_valid_q || out_adv;
  assign in_xfer  = in_valid_i && lane_adv;
  assign upd      = lane_valid_q && out_adv;
  assign in_pad   = PadW'(in_bits_i[ActN-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= '{scaled: 1'b1, unipolar: 1'b1};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sba_pkg::REG_SCALED:   mode_q.scaled   <= cfg_wdata_i[0];
        sba_pkg::REG_UNIPOLAR: mode_q.unipolar <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  for (genvar l = 0; l < Lanes; l++) begin : g_lane
    sba_lane #(
      .LCntW (LCntW)
    ) u_lane (
      .clk_i  (clk_i),
      .en_i   (in_xfer),
      .bits_i (in_pad[l*sba_pkg::LaneW +: sba_pkg::LaneW]),
      .cnt_o  (lane_cnt[l])
    );
  end

  sba_merge #(
    .InputCount (INPUT_COUNT),
    .DiffWidth  (DIFF_WIDTH),
    .Lanes      (Lanes),
    .LCntW      (LCntW),
    .ActN       (ActN)
  ) u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .upd_i      (upd),
    .mode_i     (mode_q),
    .lane_cnt_i (lane_cnt),
    .bit_o      (merge_bit)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (lane_adv) begin
        lane_valid_q <= in_valid_i;
      end
      if (out_adv) begin
        out_valid_q <= lane_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd) begin
      out_bit_q <= merge_bit;
    end
  end

  assign in_stall_o  = !lane_adv;
  assign out_valid_o = out_valid_q;
  assign out_bit_o   = out_bit_q;

endmodule
